// ----- rtl/rtc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to CMYK converter package
// Shared widths, payload types and pipeline constants.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_W      = 17;
    localparam int DEN_W      = PIX_W + 1;
    localparam int DIV_STAGES = PIX_W;
    localparam int LANES      = 3;

    // One prep stage plus one stage per quotient bit inside each lane.
    localparam int LANE_STAGES = DIV_STAGES + 1;
    // Max stage, lane stages, output register.
    localparam int PIPE_DEPTH  = LANE_STAGES + 2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [NUM_W-1:0] num_t;
    typedef logic [DEN_W-1:0] den_t;

    localparam pix_t FULL_SCALE = 8'd255;

    typedef enum logic [1:0] {
        LANE_CYAN    = 2'd0,
        LANE_MAGENTA = 2'd1,
        LANE_YELLOW  = 2'd2
    } lane_sel_t;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
    } rgb_t;

    typedef struct packed {
        pix_t cyan;
        pix_t magenta;
        pix_t yellow;
        pix_t key_black;
    } cmyk_t;

endpackage

// ----- rtl/rtc_rgb_if.sv -----
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel that carries one RGB pixel per request.
// ----------------------------------------------------------------------------
interface rtc_rgb_if;

    logic          valid;
    logic          ready;
    rtc_pkg::pix_t red_in;
    rtc_pkg::pix_t green_in;
    rtc_pkg::pix_t blue_in;

    modport source
    (
        output valid,
        output red_in,
        output green_in,
        output blue_in,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  red_in,
        input  green_in,
        input  blue_in,
        output ready
    );

endinterface

// ----------------------------------------------------------------------------
// CMYK result channel
// Valid/ready channel that carries one CMYK result per request.
// ----------------------------------------------------------------------------
interface rtc_cmyk_if;

    logic          valid;
    logic          ready;
    rtc_pkg::pix_t cyan_out;
    rtc_pkg::pix_t magenta_out;
    rtc_pkg::pix_t yellow_out;
    rtc_pkg::pix_t key_black_out;

    modport source
    (
        output valid,
        output cyan_out,
        output magenta_out,
        output yellow_out,
        output key_black_out,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  cyan_out,
        input  magenta_out,
        input  yellow_out,
        input  key_black_out,
        output ready
    );

endinterface

// ----- rtl/rtc_max_stage.sv -----
// ----------------------------------------------------------------------------
// Max channel stage
// Registers the pixel together with its largest channel.
// ----------------------------------------------------------------------------
module rtc_max_stage
(
    input  logic          clk,
    input  logic          en,
    input  rtc_pkg::rgb_t pixel,
    output rtc_pkg::pix_t w,
    output rtc_pkg::rgb_t pixel_q
);
    import rtc_pkg::*;

    pix_t w_reg;
    pix_t w_next;
    rgb_t pixel_reg;

    always_comb
    begin
        w_next = pixel.red;
        if (pixel.green > w_next)
        begin
            w_next = pixel.green;
        end
        if (pixel.blue > w_next)
        begin
            w_next = pixel.blue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w_next;
            pixel_reg <= pixel;
        end
    end

    assign w       = w_reg;
    assign pixel_q = pixel_reg;

endmodule

// ----- rtl/rtc_lane.sv -----
// ----------------------------------------------------------------------------
// Ink fraction lane
// Pipelined restoring divider for round(255*(W-ch)/W), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module rtc_lane
(
    input  logic                                clk,
    input  logic [rtc_pkg::LANE_STAGES-1:0]     en,
    input  rtc_pkg::pix_t                       w,
    input  rtc_pkg::pix_t                       ch,
    output rtc_pkg::pix_t                       q
);
    import rtc_pkg::*;

    num_t rem_reg [0:DIV_STAGES];
    den_t den_reg [0:DIV_STAGES-1];
    pix_t quo_reg [0:DIV_STAGES];

    pix_t diff;
    num_t num_next;
    den_t den_next;

    // Half-up rounding folded into the dividend: (510*d + W) / (2*W).
    always_comb
    begin
        diff     = w - ch;
        num_next = (NUM_W'(diff) << 9) - (NUM_W'(diff) << 1) + NUM_W'(w);
        den_next = {w, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= num_next;
            den_reg[0] <= den_next;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        localparam int BIT = DIV_STAGES - 1 - k;

        num_t den_sh;
        logic take;
        num_t rem_next;
        pix_t quo_next;

        always_comb
        begin
            den_sh   = NUM_W'(den_reg[k]) << BIT;
            take     = (rem_reg[k] >= den_sh);
            rem_next = take ? (rem_reg[k] - den_sh) : rem_reg[k];
            quo_next = quo_reg[k];
            quo_next[BIT] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en[k+1])
            begin
                rem_reg[k+1] <= rem_next;
                quo_reg[k+1] <= quo_next;
            end
        end

        if (k < DIV_STAGES - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en[k+1])
                begin
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign q = quo_reg[DIV_STAGES];

endmodule

// ----- rtl/rtc_merge.sv -----
// ----------------------------------------------------------------------------
// Result merge stage
// Combines the three lane quotients with the black level into the output
// register.
// ----------------------------------------------------------------------------
module rtc_merge
(
    input  logic                          clk,
    input  logic                          en,
    input  rtc_pkg::pix_t                 lane_q [rtc_pkg::LANES],
    input  rtc_pkg::pix_t                 w,
    output rtc_pkg::cmyk_t                result
);
    import rtc_pkg::*;

    cmyk_t result_reg;
    cmyk_t result_next;
    logic  black_px;

    // A black pixel never reaches a valid division; its inks are forced off.
    always_comb
    begin
        black_px                = (w == '0);
        result_next.cyan        = black_px ? '0 : lane_q[LANE_CYAN];
        result_next.magenta     = black_px ? '0 : lane_q[LANE_MAGENTA];
        result_next.yellow      = black_px ? '0 : lane_q[LANE_YELLOW];
        result_next.key_black   = FULL_SCALE - w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/rgb_to_cmyk_pixel_converter.sv -----
// A request passes the max stage, the lane stages and the output register.
// Throughput: one pixel per cycle unless the output stalls; three divider
// lanes of 8 one-bit stages each run side by side and set the latency.
// A bubble anywhere in the pipeline lets a new request in while the output
// is stalled.
// Reset (rst_n low, asynchronous) empties the pipeline; no result is valid.
// ----------------------------------------------------------------------------
// RGB to CMYK pixel converter
// Max channel stage, three pipelined ink lanes and a merge/output stage.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_pixel_converter
(
    input  logic              clk,
    input  logic              rst_n,
    rtc_rgb_if.sink           rgb,
    rtc_cmyk_if.source        cmyk
);
    import rtc_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] adv;

    rgb_t  pixel;
    rgb_t  pixel_q;
    pix_t  w_max;
    pix_t  w_line_reg [1:LANE_STAGES];
    pix_t  lane_q     [LANES];
    cmyk_t result;

    // A stage may load when it is empty or its contents move on.
    always_comb
    begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || cmyk.ready;
        for (int s = PIPE_DEPTH - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
        valid_next[0] = adv[0] ? rgb.valid : valid_reg[0];
        for (int s = 1; s < PIPE_DEPTH; s++)
        begin
            valid_next[s] = adv[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixel.red   = rgb.red_in;
    assign pixel.green = rgb.green_in;
    assign pixel.blue  = rgb.blue_in;

    rtc_max_stage u_max
    (
        .clk     (clk),
        .en      (adv[0]),
        .pixel   (pixel),
        .w       (w_max),
        .pixel_q (pixel_q)
    );

    rtc_lane u_lane_c
    (
        .clk (clk),
        .en  (adv[LANE_STAGES:1]),
        .w   (w_max),
        .ch  (pixel_q.red),
        .q   (lane_q[LANE_CYAN])
    );

    rtc_lane u_lane_m
    (
        .clk (clk),
        .en  (adv[LANE_STAGES:1]),
        .w   (w_max),
        .ch  (pixel_q.green),
        .q   (lane_q[LANE_MAGENTA])
    );

    rtc_lane u_lane_y
    (
        .clk (clk),
        .en  (adv[LANE_STAGES:1]),
        .w   (w_max),
        .ch  (pixel_q.blue),
        .q   (lane_q[LANE_YELLOW])
    );

    // The largest channel rides alongside the lanes for the merge stage.
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            w_line_reg[1] <= w_max;
        end
    end

    for (genvar s = 2; s <= LANE_STAGES; s++)
    begin : g_wline
        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                w_line_reg[s] <= w_line_reg[s-1];
            end
        end
    end

    rtc_merge u_merge
    (
        .clk    (clk),
        .en     (adv[PIPE_DEPTH-1]),
        .lane_q (lane_q),
        .w      (w_line_reg[LANE_STAGES]),
        .result (result)
    );

    assign rgb.ready           = adv[0];
    assign cmyk.valid          = valid_reg[PIPE_DEPTH-1];
    assign cmyk.cyan_out       = result.cyan;
    assign cmyk.magenta_out    = result.magenta;
    assign cmyk.yellow_out     = result.yellow;
    assign cmyk.key_black_out  = result.key_black;

endmodule

// ----- rtl/rtc_checker.sv -----
// ----------------------------------------------------------------------------
// RGB to CMYK converter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rtc_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input rtc_pkg::pix_t cyan,
    input rtc_pkg::pix_t magenta,
    input rtc_pkg::pix_t yellow,
    input rtc_pkg::pix_t key_black
);
    import rtc_pkg::*;

    // A result that is not taken stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cyan) && $stable(magenta) &&
            $stable(yellow) && $stable(key_black))
        else $error("stalled result changed");

    // Full black comes only from a black pixel, which carries no ink.
    a_black_no_ink: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_black == FULL_SCALE |->
            cyan == '0 && magenta == '0 && yellow == '0)
        else $error("black pixel with ink");

    // The largest channel always maps to zero ink.
    a_one_ink_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cyan == '0 || magenta == '0 || yellow == '0)
        else $error("no ink at zero");

    // Coming out of reset the pipeline is empty.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid after reset");

endmodule

bind rgb_to_cmyk_pixel_converter rtc_checker u_rtc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (cmyk.valid),
    .out_ready (cmyk.ready),
    .cyan      (cmyk.cyan_out),
    .magenta   (cmyk.magenta_out),
    .yellow    (cmyk.yellow_out),
    .key_black (cmyk.key_black_out)
);
